### rtl/tprp_pkg.sv
`timescale 1ns / 1ps
package tprp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned ROWQ_DEPTH  = 2;
	localparam int unsigned ROWQ_PTR_W  = $clog2(ROWQ_DEPTH);
	localparam int unsigned ROWQ_CNT_W  = $clog2(ROWQ_DEPTH + 1);

	localparam logic [BYTE_W-1:0] KEY_OFF_RESET = 8'd97;
	localparam logic [BYTE_W-1:0] MARKER_RESET  = 8'd49;
	localparam logic [BYTE_W-1:0] PACK_MARK     = 8'h80;
	localparam logic [2:0]        NOTE_SKIP     = 3'd4;

	typedef enum logic {
		CFG_KEY_OFF = 1'b0,
		CFG_MARKER  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_V1    = 2'd1,
		PH_V3    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flags;
		logic [BYTE_W-1:0] v1_note;
		logic              v1_valid;
		logic [BYTE_W-1:0] v3_note;
		logic              v3_valid;
	} row_t;

	typedef struct packed {
		logic   busy;
		phase_t phase;
		logic   v1_valid;
		logic   v3_valid;
	} back_stat_t;

endpackage

### rtl/tprp_front.sv
`timescale 1ns / 1ps
module tprp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_fire,
	input  logic [tprp_pkg::BYTE_W-1:0] data_byte,
	input  logic                      pattern_start,
	input  logic [tprp_pkg::BYTE_W-1:0] key_off_note,
	input  logic [tprp_pkg::BYTE_W-1:0] marker_note,
	output logic                      push,
	output tprp_pkg::row_t            row
);
	import tprp_pkg::*;

	logic [1:0]        chan_q;
	logic              await_q;
	logic [2:0]        skip_q;
	logic [BYTE_W-1:0] flags_q;
	logic [BYTE_W-1:0] v1_note_q;
	logic              v1_valid_q;
	logic [BYTE_W-1:0] v3_note_q;
	logic              v3_valid_q;

	logic [1:0]        chan_e;
	logic              await_e;
	logic [2:0]        skip_e;
	row_t              cur;
	row_t              nxt_row;
	logic              await_n;
	logic [2:0]        skip_n;
	logic              take;
	logic              chan_done;
	logic [2:0]        nskip;
	logic              is_koff;

	assign nskip = {2'b0, data_byte[1]} + {2'b0, data_byte[2]}
	             + {2'b0, data_byte[3]} + {2'b0, data_byte[4]};
	assign is_koff = (data_byte == key_off_note);

	always_comb begin
		// a pattern start wipes the row before this byte is taken
		chan_e  = pattern_start ? 2'd0 : chan_q;
		await_e = pattern_start ? 1'b0 : await_q;
		skip_e  = pattern_start ? 3'd0 : skip_q;
		cur.flags    = pattern_start ? '0 : flags_q;
		cur.v1_note  = pattern_start ? '0 : v1_note_q;
		cur.v1_valid = pattern_start ? 1'b0 : v1_valid_q;
		cur.v3_note  = pattern_start ? '0 : v3_note_q;
		cur.v3_valid = pattern_start ? 1'b0 : v3_valid_q;

		take      = 1'b0;
		chan_done = 1'b0;
		await_n   = await_e;
		skip_n    = skip_e;
		if (await_e) begin
			take      = 1'b1;
			await_n   = 1'b0;
			chan_done = (skip_e == 3'd0);
		end else if (skip_e != 3'd0) begin
			skip_n    = skip_e - 3'd1;
			chan_done = (skip_e == 3'd1);
		end else if ((data_byte & PACK_MARK) != '0) begin
			skip_n    = nskip;
			await_n   = data_byte[0];
			chan_done = !data_byte[0] && (nskip == 3'd0);
		end else begin
			take   = 1'b1;
			skip_n = NOTE_SKIP;
		end

		nxt_row = cur;
		if (take) begin
			nxt_row.flags = cur.flags | (PACK_MARK >> chan_e);
			case (chan_e)
				2'd0: if (!is_koff) nxt_row.flags[1] = 1'b1;
				2'd2: if (!is_koff) nxt_row.flags[0] = 1'b1;
				2'd1: begin
					if (is_koff) begin
						nxt_row.flags[2] = 1'b1;
					end else if (data_byte == marker_note) begin
						nxt_row.flags[3] = 1'b1;
					end else begin
						nxt_row.v1_note  = data_byte;
						nxt_row.v1_valid = 1'b1;
					end
				end
				default: begin
					nxt_row.v3_note  = data_byte;
					nxt_row.v3_valid = 1'b1;
				end
			endcase
		end
	end

	assign push = in_fire && chan_done && (chan_e == 2'd3);
	assign row  = nxt_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q     <= '0;
			await_q    <= 1'b0;
			skip_q     <= '0;
			flags_q    <= '0;
			v1_note_q  <= '0;
			v1_valid_q <= 1'b0;
			v3_note_q  <= '0;
			v3_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (push) begin
				chan_q     <= '0;
				await_q    <= 1'b0;
				skip_q     <= '0;
				flags_q    <= '0;
				v1_note_q  <= '0;
				v1_valid_q <= 1'b0;
				v3_note_q  <= '0;
				v3_valid_q <= 1'b0;
			end else begin
				chan_q     <= chan_done ? chan_e + 2'd1 : chan_e;
				await_q    <= await_n;
				skip_q     <= skip_n;
				flags_q    <= nxt_row.flags;
				v1_note_q  <= nxt_row.v1_note;
				v1_valid_q <= nxt_row.v1_valid;
				v3_note_q  <= nxt_row.v3_note;
				v3_valid_q <= nxt_row.v3_valid;
			end
		end
	end

endmodule

### rtl/tprp_rowq.sv
`timescale 1ns / 1ps
module tprp_rowq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  tprp_pkg::row_t                    wr_row,
	input  logic                              pop,
	output tprp_pkg::row_t                    rd_row,
	output logic                              full,
	output logic                              empty,
	output logic [tprp_pkg::ROWQ_CNT_W-1:0]   count
);
	import tprp_pkg::*;

	row_t                  mem_q [ROWQ_DEPTH];
	logic [ROWQ_PTR_W-1:0] wr_ptr_q;
	logic [ROWQ_PTR_W-1:0] rd_ptr_q;
	logic [ROWQ_CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == ROWQ_CNT_W'(ROWQ_DEPTH));
	assign empty  = (cnt_q == '0);
	assign count  = cnt_q;
	assign rd_row = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ROWQ_PTR_W'(ROWQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ROWQ_PTR_W'(ROWQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/tprp_back.sv
`timescale 1ns / 1ps
module tprp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tprp_pkg::row_t                rd_row,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tprp_pkg::BYTE_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output tprp_pkg::back_stat_t          stat
);
	import tprp_pkg::*;

	row_t   row_q;
	logic   busy_q;
	phase_t phase_q;
	logic   fire;

	always_comb begin
		case (phase_q)
			PH_FLAGS: begin
				m_tdata = row_q.flags;
				m_tlast = !row_q.v1_valid && !row_q.v3_valid;
			end
			PH_V1: begin
				m_tdata = row_q.v1_note;
				m_tlast = !row_q.v3_valid;
			end
			default: begin
				m_tdata = row_q.v3_note;
				m_tlast = 1'b1;
			end
		endcase
	end

	assign m_tvalid = busy_q;
	assign fire     = busy_q && m_tready;
	// load the next row when idle or as the last byte of this one leaves
	assign pop      = !empty && (!busy_q || (fire && m_tlast));

	assign stat.busy     = busy_q;
	assign stat.phase    = phase_q;
	assign stat.v1_valid = row_q.v1_valid;
	assign stat.v3_valid = row_q.v3_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q <= rd_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_FLAGS;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= PH_FLAGS;
		end else if (fire) begin
			if (m_tlast) begin
				busy_q  <= 1'b0;
				phase_q <= PH_FLAGS;
			end else if (phase_q == PH_FLAGS && row_q.v1_valid) begin
				phase_q <= PH_V1;
			end else begin
				phase_q <= PH_V3;
			end
		end
	end

endmodule

### rtl/tracker_pattern_row_packer_top.sv
`timescale 1ns / 1ps
// Packed tracker pattern row decoder, four channels.
// Input stream: s_tdata carries one byte of packed pattern data, s_tuser
// flags the first byte of a pattern (row state is cleared before it is used).
// Output stream: per finished row a flags byte, then the kept channel-1 note
// and the kept channel-3 note when present; m_tlast marks the row's final byte.
// Config channel: cfg_index 0 writes the key-off note (reset 97), index 1
// the marker note (reset 49); always ready. Write only while idle.
// Throughput: one input byte per cycle while s_tready is high, one output byte per
// cycle while m_tready is high. A row takes at least four input bytes and yields
// at most three, so the output side keeps up. The first byte of a row appears on
// m_tvalid once the row is written into the queue and loaded into the output stage.
// A two-entry row queue sits between the decoder and the output serializer;
// when the receiver stalls the queue fills and s_tready drops only once both
// entries hold rows, so decoding continues through short stalls.
// Reset (arst_n low) clears decoder state, the queue and the output stage and
// restores both config registers to their reset values.
module tracker_pattern_row_packer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tprp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] pattern_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tprp_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
	output logic                          m_tlast,   // last_of_row
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  tprp_pkg::cfg_idx_t            cfg_index,
	input  logic [tprp_pkg::BYTE_W-1:0]   cfg_data
);
	import tprp_pkg::*;

	logic [BYTE_W-1:0]     key_off_q;
	logic [BYTE_W-1:0]     marker_q;
	logic                  in_fire;
	logic                  push;
	logic                  pop;
	row_t                  wr_row;
	row_t                  rd_row;
	logic                  full;
	logic                  empty;
	logic [ROWQ_CNT_W-1:0] count;
	back_stat_t            stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign in_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_off_q <= KEY_OFF_RESET;
			marker_q  <= MARKER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_OFF: key_off_q <= cfg_data;
				CFG_MARKER:  marker_q  <= cfg_data;
				default:     key_off_q <= key_off_q;
			endcase
		end
	end

	tprp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.data_byte     (s_tdata),
		.pattern_start (s_tuser),
		.key_off_note  (key_off_q),
		.marker_note   (marker_q),
		.push          (push),
		.row           (wr_row)
	);

	tprp_rowq u_rowq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_row (wr_row),
		.pop    (pop),
		.rd_row (rd_row),
		.full   (full),
		.empty  (empty),
		.count  (count)
	);

	tprp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_row   (rd_row),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.stat     (stat)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= ROWQ_CNT_W'(ROWQ_DEPTH))
		else $error("row queue over depth");

	a_push_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_fire)
		else $error("row pushed without an input item");

	a_v1_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && stat.phase == PH_V1) |-> stat.v1_valid)
		else $error("channel-1 note sent but not kept");

	a_v3_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && stat.phase == PH_V3) |-> stat.v3_valid)
		else $error("channel-3 note sent but not kept");

	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !empty) |=> (m_tvalid && stat.phase == PH_FLAGS))
		else $error("queued row not loaded after row end");

endmodule

### verif/tracker_pattern_row_packer_checker.sv
`timescale 1ns / 1ps
module tracker_pattern_row_packer_checker
	import tprp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [BYTE_W-1:0] m_tdata,
	input  logic              m_tlast,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  cfg_idx_t          cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	output int                mismatches,
	output int                pending,
	output int                rows_done,
	output int                bytes_checked
);

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              is_last;
	} row_byte_t;

	row_byte_t row_bytes_q[$];
	row_byte_t want;
	logic      bad;

	// decoder copy
	logic [BYTE_W-1:0] key_off_code;
	logic [BYTE_W-1:0] marker_code;
	logic [1:0]        chan;
	logic              note_due;
	logic [2:0]        skips_left;
	logic [BYTE_W-1:0] flag_bits;
	logic [BYTE_W-1:0] ch1_note;
	logic              ch1_kept;
	logic [BYTE_W-1:0] ch3_note;
	logic              ch3_kept;

	task automatic clear_row_state();
		chan       = 2'd0;
		note_due   = 1'b0;
		skips_left = 3'd0;
		flag_bits  = '0;
		ch1_note   = '0;
		ch1_kept   = 1'b0;
		ch3_note   = '0;
		ch3_kept   = 1'b0;
	endtask

	task automatic take_note(input logic [BYTE_W-1:0] note);
		flag_bits = flag_bits | (8'h80 >> chan);
		case (chan)
			2'd0: begin
				if (note != key_off_code) flag_bits = flag_bits | 8'h02;
			end
			2'd1: begin
				// key-off wins over the marker when both match
				if (note == key_off_code) flag_bits = flag_bits | 8'h04;
				else if (note == marker_code) flag_bits = flag_bits | 8'h08;
				else begin
					ch1_note = note;
					ch1_kept = 1'b1;
				end
			end
			2'd2: begin
				if (note != key_off_code) flag_bits = flag_bits | 8'h01;
			end
			default: begin
				ch3_note = note;
				ch3_kept = 1'b1;
			end
		endcase
	endtask

	task automatic close_channel();
		if (chan != 2'd3) begin
			chan = chan + 2'd1;
		end else begin
			row_bytes_q.push_back('{value: flag_bits, is_last: 1'b0});
			if (ch1_kept) row_bytes_q.push_back('{value: ch1_note, is_last: 1'b0});
			if (ch3_kept) row_bytes_q.push_back('{value: ch3_note, is_last: 1'b0});
			row_bytes_q[row_bytes_q.size() - 1].is_last = 1'b1;
			clear_row_state();
		end
	endtask

	task automatic decode_packed_byte(input logic [BYTE_W-1:0] b, input logic first);
		if (first) clear_row_state();
		if (note_due) begin
			note_due = 1'b0;
			take_note(b);
			if (skips_left == 3'd0) close_channel();
		end else if (skips_left != 3'd0) begin
			skips_left = skips_left - 3'd1;
			if (skips_left == 3'd0) close_channel();
		end else if (b[7]) begin
			// bits 5 and 6 carry nothing
			skips_left = {2'b00, b[1]} + {2'b00, b[2]} + {2'b00, b[3]} + {2'b00, b[4]};
			note_due   = b[0];
			if (!b[0] && skips_left == 3'd0) close_channel();
		end else begin
			take_note(b);
			skips_left = NOTE_SKIP;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_off_code = KEY_OFF_RESET;
			marker_code  = MARKER_RESET;
			clear_row_state();
			row_bytes_q.delete();
			mismatches    <= 0;
			pending       <= 0;
			rows_done     <= 0;
			bytes_checked <= 0;
		end else begin
			// compare first: an item taken at this edge cannot show up at the same edge
			if (m_tvalid && m_tready) begin
				if (row_bytes_q.size() == 0) begin
					$display("%0t: unexpected item out_byte %02h last %0b, none expected",
						$time, m_tdata, m_tlast);
					mismatches <= mismatches + 1;
				end else begin
					want = row_bytes_q.pop_front();
					bad  = 1'b0;
					if (m_tdata !== want.value) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.value, m_tdata);
						bad = 1'b1;
					end
					if (m_tlast !== want.is_last) begin
						$display("%0t: last_of_row expected %0b actual %0b",
							$time, want.is_last, m_tlast);
						bad = 1'b1;
					end
					if (bad) mismatches <= mismatches + 1;
					bytes_checked <= bytes_checked + 1;
					if (want.is_last) rows_done <= rows_done + 1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEY_OFF: key_off_code = cfg_data;
					CFG_MARKER:  marker_code  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) decode_packed_byte(s_tdata, s_tuser);
			pending <= row_bytes_q.size();
		end
	end

endmodule

### verif/tracker_pattern_row_packer_top_tb.sv
`timescale 1ns / 1ps
module tracker_pattern_row_packer_top_tb;
	import tprp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 120;
	localparam int SETTLE_IDLE  = 8;
	localparam int PHASE_BYTES  = 12;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_idx_t          cfg_index;
	logic [BYTE_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int rows_done;
	int bytes_checked;

	logic s_fire = 1'b0;
	logic cfg_fire = 1'b0;
	bit   hold_req = 1'b0;
	int   cycle_count = 0;
	int   items_sent = 0;
	int   settings_run = 1;

	logic [BYTE_W-1:0] cur_key_off = KEY_OFF_RESET;
	logic [BYTE_W-1:0] cur_marker  = MARKER_RESET;

	tracker_pattern_row_packer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tracker_pattern_row_packer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.rows_done     (rows_done),
		.bytes_checked (bytes_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// handshake seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		s_fire   <= s_tvalid && s_tready;
		cfg_fire <= cfg_valid && cfg_ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected", cycle_count, pending);
			$display("tracker_pattern_row_packer_top_tb: done, errors");
			$finish;
		end
	end

	// receiver: random ready runs, plus one long hold-off on request
	initial begin
		int   run_left;
		logic run_ready;
		int   r;
		run_left  = 0;
		run_ready = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 19);
					if (r < 10) begin
						run_ready = 1'b1;
						run_left  = $urandom_range(1, 6);
					end else if (r < 14) begin
						run_ready = 1'b1;
						run_left  = $urandom_range(20, 40);
					end else if (r < 19) begin
						run_ready = 1'b0;
						run_left  = $urandom_range(1, 3);
					end else begin
						run_ready = 1'b0;
						run_left  = $urandom_range(10, 30);
					end
				end
				m_tready <= run_ready;
				run_left = run_left - 1;
			end
		end
	end

	function automatic int pick_gap(input bit gapless);
		int r;
		r = $urandom_range(0, 49);
		if (gapless || r < 30) return 0;
		if (r < 43) return $urandom_range(1, 2);
		if (r < 49) return $urandom_range(3, 6);
		return $urandom_range(12, 30);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_note();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return cur_key_off;
		if (r < 4) return cur_marker;
		return BYTE_W'($urandom);
	endfunction

	task automatic pause_sender(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_item(input logic [BYTE_W-1:0] data, input logic start);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= start;
		do @(negedge clk); while (!s_fire);
		items_sent++;
	endtask

	task automatic offer_byte(input logic [BYTE_W-1:0] data, input logic start,
			input bit gapless);
		pause_sender(pick_gap(gapless));
		send_item(data, start);
	endtask

	// one channel of a row, either a bare note or a packing byte with its payload
	task automatic send_channel(input logic start, input bit gapless);
		logic [BYTE_W-1:0] pack;
		int                skips;
		if ($urandom_range(0, 9) < 3) begin
			offer_byte(pick_note() & 8'h7F, start, gapless);
			repeat (4) offer_byte(BYTE_W'($urandom), 1'b0, gapless);
		end else begin
			pack = PACK_MARK | (BYTE_W'($urandom) & 8'h60);
			if ($urandom_range(0, 9) < 7) pack[0] = 1'b1;
			if ($urandom_range(0, 1) == 1) pack[4:1] = 4'($urandom);
			skips = pack[1] + pack[2] + pack[3] + pack[4];
			offer_byte(pack, start, gapless);
			if (pack[0]) offer_byte(pick_note(), 1'b0, gapless);
			repeat (skips) offer_byte(BYTE_W'($urandom), 1'b0, gapless);
		end
	endtask

	task automatic send_row(input logic start, input bit gapless);
		send_channel(start, gapless);
		repeat (3) send_channel(1'b0, gapless);
	endtask

	task automatic random_phase(input int budget);
		int stop_at;
		int r;
		bit resync;
		stop_at = items_sent + budget;
		resync  = 1'b1;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				send_row(resync || r == 0, $urandom_range(0, 3) == 0);
				resync = 1'b0;
			end else if (r < 9) begin
				// row cut short by the next pattern start
				send_channel(1'b1, 1'b0);
				repeat ($urandom_range(0, 2)) send_channel(1'b0, 1'b0);
				if ($urandom_range(0, 1) == 1) offer_byte(8'h81, 1'b0, 1'b0);
				resync = 1'b1;
			end else begin
				repeat ($urandom_range(1, 6))
					offer_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0, 1'b0);
				resync = 1'b1;
			end
		end
	endtask

	task automatic settle();
		pause_sender(1);
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_IDLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
		if (idx == CFG_KEY_OFF) cur_key_off = value;
		else cur_marker = value;
	endtask

	task automatic new_setting(input logic [BYTE_W-1:0] key_off, input logic [BYTE_W-1:0] marker);
		settle();
		write_reg(CFG_KEY_OFF, key_off);
		@(negedge clk);
		write_reg(CFG_MARKER, marker);
		settings_run++;
	endtask

	initial begin
		logic [BYTE_W-1:0] shared;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KEY_OFF;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// key-off on ch0, marker on ch1, 0xFF on ch2, 0x00 kept on ch3
		offer_byte(8'h81, 1'b1, 1'b0); offer_byte(KEY_OFF_RESET, 1'b0, 1'b0);
		offer_byte(8'h81, 1'b0, 1'b0); offer_byte(MARKER_RESET, 1'b0, 1'b0);
		offer_byte(8'h81, 1'b0, 1'b0); offer_byte(8'hFF, 1'b0, 1'b0);
		offer_byte(8'h81, 1'b0, 1'b0); offer_byte(8'h00, 1'b0, 1'b0);
		// bare note with four skips, ignored bits 5/6, empty channel, all skip bits
		offer_byte(8'h7F, 1'b0, 1'b0);
		offer_byte(8'hFF, 1'b0, 1'b0); offer_byte(8'h00, 1'b0, 1'b0);
		offer_byte(8'hAA, 1'b0, 1'b0); offer_byte(8'h55, 1'b0, 1'b0);
		offer_byte(8'hE1, 1'b0, 1'b0); offer_byte(KEY_OFF_RESET, 1'b0, 1'b0);
		offer_byte(8'h80, 1'b0, 1'b0);
		offer_byte(8'h9F, 1'b0, 1'b0); offer_byte(8'hC8, 1'b0, 1'b0);
		offer_byte(8'h01, 1'b0, 1'b0); offer_byte(8'h02, 1'b0, 1'b0);
		offer_byte(8'h04, 1'b0, 1'b0); offer_byte(8'h08, 1'b0, 1'b0);
		// drop a started row, then a row with a kept ch1 note and key-off on ch2
		offer_byte(8'h81, 1'b1, 1'b0);
		offer_byte(8'h80, 1'b1, 1'b0);
		offer_byte(8'h81, 1'b0, 1'b0); offer_byte(8'h12, 1'b0, 1'b0);
		offer_byte(8'h81, 1'b0, 1'b0); offer_byte(KEY_OFF_RESET, 1'b0, 1'b0);
		offer_byte(8'h80, 1'b0, 1'b0);
		random_phase(PHASE_BYTES);

		new_setting(8'h00, 8'hFF);
		// fill the row queue while the receiver holds off
		hold_req = 1'b1;
		repeat (8) begin
			offer_byte(8'h80, 1'b1, 1'b1);
			offer_byte(8'h81, 1'b0, 1'b1); offer_byte(pick_note(), 1'b0, 1'b1);
			offer_byte(8'hA0, 1'b0, 1'b1);
			offer_byte(8'h81, 1'b0, 1'b1); offer_byte(pick_note(), 1'b0, 1'b1);
		end
		random_phase(PHASE_BYTES);

		new_setting(8'hFF, 8'h00);
		random_phase(PHASE_BYTES);

		shared = BYTE_W'($urandom);
		new_setting(shared, shared);
		random_phase(PHASE_BYTES);

		new_setting(BYTE_W'($urandom), BYTE_W'($urandom));
		random_phase(PHASE_BYTES);

		settle();
		$display("covered %0d input bytes over %0d register settings, incl. a long output hold-off",
			items_sent, settings_run);
		$display("checked %0d rows, %0d output bytes, %0d bad", rows_done, bytes_checked,
			mismatches);
		if (mismatches == 0) begin
			$display("tracker_pattern_row_packer_top_tb: done, clean");
		end else begin
			$display("tracker_pattern_row_packer_top_tb: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
rtl/tprp_pkg.sv
rtl/tprp_front.sv
rtl/tprp_rowq.sv
rtl/tprp_back.sv
rtl/tracker_pattern_row_packer_top.sv
verif/tracker_pattern_row_packer_checker.sv
verif/tracker_pattern_row_packer_top_tb.sv
